>>> src/acir_pkg.sv
// Shared types and constants for the AABB contact impulse resolve unit.
`timescale 1ns / 1ps
package acir_pkg;

    localparam logic [2:0] NORMAL_NONE  = 3'd0;
    localparam logic [2:0] NORMAL_NEG_X = 3'd1;
    localparam logic [2:0] NORMAL_POS_X = 3'd2;
    localparam logic [2:0] NORMAL_NEG_Y = 3'd3;
    localparam logic [2:0] NORMAL_POS_Y = 3'd4;

    localparam logic CFG_PERCENT = 1'b0;
    localparam logic CFG_SLOP    = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [30:0]        sum_half_width;
        logic [30:0]        sum_half_height;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic [30:0]        inv_mass_a;
        logic [30:0]        inv_mass_b;
        logic [16:0]        bounce_a;
        logic [16:0]        bounce_b;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic [2:0]         normal_code;
        logic [30:0]        penetration;
        logic signed [31:0] vel_change_a;
        logic signed [31:0] vel_change_b;
        logic signed [31:0] pos_change_a;
        logic signed [31:0] pos_change_b;
    } t_result;

    // Result fields that need no arithmetic plus the zeroing flags.
    typedef struct packed {
        logic        hit;
        logic [2:0]  normal_code;
        logic [30:0] penetration;
        logic        vel_zero;
        logic        pos_zero;
    } t_side;

    // A classified pair, handed from the front end to the back end.
    typedef struct packed {
        t_side       side;
        logic [31:0] neg_vn;
        logic [31:0] mass_sum;
        logic [16:0] bounce;
        logic [30:0] excess;
        logic [30:0] inv_mass_a;
        logic [30:0] inv_mass_b;
    } t_job;

endpackage

>>> src/aabb_contact_impulse_resolve_unit.sv
// Top level of the AABB contact impulse resolve unit.
//
//   Channel   Handshake            Payload
//   input     i_push / o_full      i_item   (t_item)
//   result    o_empty / i_pop      o_result (t_result)
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One pair per cycle sustained while results are popped. A result passes
// through the front register and the queue, then 3 arithmetic stages,
// TW + 1 divider stages (TW = max(FRAC_BITS,17) + 33 -
// FRAC_BITS, 34 by default) and the result register. The four pipelined
// dividers set that depth. Reset is synchronous. When
// the result is not popped the back end holds and the queue and front end
// keep taking transactions until the queue fills.
`timescale 1ns / 1ps
module aabb_contact_impulse_resolve_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  acir_pkg::t_item   i_item,
    output logic              o_empty,
    input  logic              i_pop,
    output acir_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [30:0]       i_cfg_data
);

    localparam int PERCENT_RST = ((1 << FRAC_BITS) * 2 + 5) / 10;
    localparam int SLOP_RST    = ((1 << FRAC_BITS) + 5) / 10;

    logic [16:0]    r_percent;
    logic [30:0]    r_slop;

    logic           job_vld, queue_full, queue_empty, job_take;
    acir_pkg::t_job front_job, queue_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_percent <= 17'(PERCENT_RST);
            r_slop    <= 31'(SLOP_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acir_pkg::CFG_PERCENT: r_percent <= i_cfg_data[16:0];
                acir_pkg::CFG_SLOP:    r_slop    <= i_cfg_data;
                default:               r_slop    <= r_slop;
            endcase
        end
    end

    acir_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_item       (i_item),
        .i_slop       (r_slop),
        .o_job_vld    (job_vld),
        .o_job        (front_job),
        .i_queue_full (queue_full)
    );

    acir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_vld),
        .i_data  (front_job),
        .o_full  (queue_full),
        .i_pop   (job_take),
        .o_empty (queue_empty),
        .o_data  (queue_job)
    );

    acir_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_vld  (!queue_empty),
        .i_job      (queue_job),
        .o_job_take (job_take),
        .i_percent  (r_percent),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_result   (o_result)
    );

endmodule

>>> src/acir_front.sv
// Front end: accepts a pair, finds the contact and classifies it into a job.
`timescale 1ns / 1ps
module acir_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  acir_pkg::t_item   i_item,
    input  logic [30:0]       i_slop,
    output logic              o_job_vld,
    output acir_pkg::t_job    o_job,
    input  logic              i_queue_full
);

    logic                r_vld;
    acir_pkg::t_job      r_job;
    acir_pkg::t_job      n_job;
    logic                load;

    logic signed [33:0]  ox_s, oy_s, ax, ay, xov, yov;
    logic signed [32:0]  vn_s;
    logic                hit, use_x, sep;
    logic [30:0]         pen;
    logic signed [31:0]  ex_s;
    logic [31:0]         msum;

    assign load   = !r_vld || !i_queue_full;
    assign o_full = !load;

    always_comb begin
        ox_s = 34'(i_item.offset_x);
        oy_s = 34'(i_item.offset_y);
        ax   = (ox_s < 0) ? -ox_s : ox_s;
        ay   = (oy_s < 0) ? -oy_s : oy_s;
        xov  = $signed({3'b000, i_item.sum_half_width}) - ax;
        yov  = $signed({3'b000, i_item.sum_half_height}) - ay;
        hit  = (xov > 0) && (yov > 0);
        // Equal overlaps pick the y axis.
        use_x = xov < yov;
        pen   = use_x ? xov[30:0] : yov[30:0];
        if (use_x) begin
            vn_s = (ox_s < 0) ? -33'(i_item.rel_vel_x) : 33'(i_item.rel_vel_x);
        end else begin
            vn_s = (oy_s < 0) ? -33'(i_item.rel_vel_y) : 33'(i_item.rel_vel_y);
        end
        sep  = vn_s > 0;
        msum = 32'(i_item.inv_mass_a) + 32'(i_item.inv_mass_b);
        ex_s = $signed({1'b0, pen}) - $signed({1'b0, i_slop});

        n_job = '0;
        n_job.side.hit      = hit;
        n_job.side.vel_zero = 1'b1;
        n_job.side.pos_zero = 1'b1;
        if (hit) begin
            if (use_x) begin
                n_job.side.normal_code = (ox_s < 0) ? acir_pkg::NORMAL_NEG_X
                                                    : acir_pkg::NORMAL_POS_X;
            end else begin
                n_job.side.normal_code = (oy_s < 0) ? acir_pkg::NORMAL_NEG_Y
                                                    : acir_pkg::NORMAL_POS_Y;
            end
            n_job.side.penetration = pen;
            n_job.side.pos_zero    = (msum == 32'd0);
            n_job.side.vel_zero    = (msum == 32'd0) || sep;
        end
        n_job.neg_vn     = sep ? 32'd0 : 32'(-vn_s);
        n_job.mass_sum   = msum;
        n_job.bounce     = (i_item.bounce_a < i_item.bounce_b) ? i_item.bounce_a
                                                               : i_item.bounce_b;
        n_job.excess     = (ex_s < 0) ? 31'd0 : ex_s[30:0];
        n_job.inv_mass_a = i_item.inv_mass_a;
        n_job.inv_mass_b = i_item.inv_mass_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= n_job;
        end
    end

    assign o_job_vld = r_vld;
    assign o_job     = r_job;

endmodule

>>> src/acir_queue.sv
// Short queue of classified jobs between the front and back ends.
`timescale 1ns / 1ps
module acir_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  acir_pkg::t_job    i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output acir_pkg::t_job    o_data
);

    acir_pkg::t_job                r_mem [acir_pkg::QUEUE_DEPTH];
    logic [acir_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [acir_pkg::QUEUE_AW:0]   r_count;
    logic                          wr, rd;

    assign o_full  = r_count == (acir_pkg::QUEUE_AW+1)'(acir_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/acir_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module acir_div #(
    parameter int QW = 34
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [QW+30:0]    i_num,
    input  logic [31:0]       i_den,
    output logic [QW-1:0]     o_quo
);

    // The caller guarantees the quotient fits in QW bits, so the top bits of
    // the numerator are already below the divisor.
    logic [31:0]   r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [31:0]   r_den [QW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num[QW+30:QW]};
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [32:0] cand;
        logic        take;
        assign cand = {r_rem[k-1], r_low[k-1][QW-1]};
        assign take = cand >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? 32'(cand - {1'b0, r_den[k-1]}) : cand[31:0];
                r_low[k] <= r_low[k-1] << 1;
                r_quo[k] <= {r_quo[k-1][QW-2:0], take};
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW];

endmodule

>>> src/acir_back.sv
// Back end: impulse and correction arithmetic, divides and result register.
`timescale 1ns / 1ps
module acir_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_vld,
    input  acir_pkg::t_job    i_job,
    output logic              o_job_take,
    input  logic [16:0]       i_percent,
    output logic              o_empty,
    input  logic              i_pop,
    output acir_pkg::t_result o_result
);

    localparam int OW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int TW  = OW + 32 - FRAC_BITS;
    localparam int NW  = TW + 31;
    localparam int DL  = TW + 1;

    logic en;

    // Stage 1: scale by restitution and by the correction percent.
    logic              r1_vld;
    acir_pkg::t_side   r1_side;
    logic [31:0]       r1_msum;
    logic [30:0]       r1_ia, r1_ib;
    logic [TW-1:0]     r1_tv, r1_tp;
    logic [OW+31:0]    pv;
    logic [47:0]       pa;

    // Stage 2: partial products against the inverse masses.
    logic              r2_vld;
    acir_pkg::t_side   r2_side;
    logic [31:0]       r2_msum;
    logic [TW+15:0]    r2_val, r2_vbl, r2_pal, r2_pbl;
    logic [TW+14:0]    r2_vah, r2_vbh, r2_pah, r2_pbh;

    // Stage 3: numerators.
    logic              r3_vld;
    acir_pkg::t_side   r3_side;
    logic [31:0]       r3_msum;
    logic [NW-1:0]     r3_nva, r3_nvb, r3_npa, r3_npb;

    logic              r_dvld  [DL];
    acir_pkg::t_side   r_dside [DL];
    logic [TW-1:0]     qva, qvb, qpa, qpb;

    logic              r_out_vld;
    acir_pkg::t_result r_out, n_out;

    assign en         = !r_out_vld || i_pop;
    assign o_job_take = en && i_job_vld;

    always_comb begin
        pv = (OW+32)'((OW'(1) << FRAC_BITS) + OW'(i_job.bounce));
        pv = pv * (OW+32)'(i_job.neg_vn);
        pa = 48'(i_job.excess) * 48'(i_percent);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < DL; i++) begin
                r_dvld[i] <= 1'b0;
            end
        end else if (en) begin
            r1_vld    <= i_job_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r_dvld[0] <= r3_vld;
            for (int i = 1; i < DL; i++) begin
                r_dvld[i] <= r_dvld[i-1];
            end
            r_out_vld <= r_dvld[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= i_job.side;
            r1_msum <= i_job.mass_sum;
            r1_ia   <= i_job.inv_mass_a;
            r1_ib   <= i_job.inv_mass_b;
            r1_tv   <= pv[OW+31:FRAC_BITS];
            r1_tp   <= TW'(pa >> FRAC_BITS);

            r2_side <= r1_side;
            r2_msum <= r1_msum;
            r2_val  <= (TW+16)'(r1_tv) * (TW+16)'(r1_ia[15:0]);
            r2_vah  <= (TW+15)'(r1_tv) * (TW+15)'(r1_ia[30:16]);
            r2_vbl  <= (TW+16)'(r1_tv) * (TW+16)'(r1_ib[15:0]);
            r2_vbh  <= (TW+15)'(r1_tv) * (TW+15)'(r1_ib[30:16]);
            r2_pal  <= (TW+16)'(r1_tp) * (TW+16)'(r1_ia[15:0]);
            r2_pah  <= (TW+15)'(r1_tp) * (TW+15)'(r1_ia[30:16]);
            r2_pbl  <= (TW+16)'(r1_tp) * (TW+16)'(r1_ib[15:0]);
            r2_pbh  <= (TW+15)'(r1_tp) * (TW+15)'(r1_ib[30:16]);

            r3_side <= r2_side;
            r3_msum <= r2_msum;
            r3_nva  <= NW'(r2_val) + (NW'(r2_vah) << 16);
            r3_nvb  <= NW'(r2_vbl) + (NW'(r2_vbh) << 16);
            r3_npa  <= NW'(r2_pal) + (NW'(r2_pah) << 16);
            r3_npb  <= NW'(r2_pbl) + (NW'(r2_pbh) << 16);

            r_dside[0] <= r3_side;
            for (int i = 1; i < DL; i++) begin
                r_dside[i] <= r_dside[i-1];
            end

            r_out <= n_out;
        end
    end

    acir_div #(.QW(TW)) u_div_va (
        .i_clk(i_clk), .i_en(en), .i_num(r3_nva), .i_den(r3_msum), .o_quo(qva));
    acir_div #(.QW(TW)) u_div_vb (
        .i_clk(i_clk), .i_en(en), .i_num(r3_nvb), .i_den(r3_msum), .o_quo(qvb));
    acir_div #(.QW(TW)) u_div_pa (
        .i_clk(i_clk), .i_en(en), .i_num(r3_npa), .i_den(r3_msum), .o_quo(qpa));
    acir_div #(.QW(TW)) u_div_pb (
        .i_clk(i_clk), .i_en(en), .i_num(r3_npb), .i_den(r3_msum), .o_quo(qpb));

    // Body A moves against the normal and B along it, both saturated.
    always_comb begin
        n_out             = '0;
        n_out.hit         = r_dside[DL-1].hit;
        n_out.normal_code = r_dside[DL-1].normal_code;
        n_out.penetration = r_dside[DL-1].penetration;
        if (!r_dside[DL-1].vel_zero) begin
            n_out.vel_change_a = (qva[TW-1:31] != '0) ? 32'sh8000_0000
                                                      : -$signed({1'b0, qva[30:0]});
            n_out.vel_change_b = (qvb[TW-1:31] != '0) ? 32'sh7FFF_FFFF
                                                      : $signed({1'b0, qvb[30:0]});
        end
        if (!r_dside[DL-1].pos_zero) begin
            n_out.pos_change_a = (qpa[TW-1:31] != '0) ? 32'sh8000_0000
                                                      : -$signed({1'b0, qpa[30:0]});
            n_out.pos_change_b = (qpb[TW-1:31] != '0) ? 32'sh7FFF_FFFF
                                                      : $signed({1'b0, qpb[30:0]});
        end
    end

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

endmodule
